### rtl/core/arpc_pkg.sv
// Package for the ARP cache: sizes, codes and transaction types.
package arpc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned AGE_W   = 16;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STS_W   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX    = '1;
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(ENTRIES - 1);
  localparam logic [AGE_W-1:0] AGE_RESET  = AGE_W'(60);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP  = 3'd0,
    KIND_INSERT  = 3'd1,
    KIND_REFRESH = 3'd2,
    KIND_TICK    = 3'd3,
    KIND_SWEEP   = 3'd4
  } kind_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IP_W-1:0]   ip_addr;
    logic [MAC_W-1:0]  mac_addr;
  } in_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [MAC_W-1:0] found_mac;
    logic [CNT_W-1:0] removed;
  } out_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TICK_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

### rtl/core/arpc_ram.sv
// Single-port-write, registered-read RAM for the cache entries.
module arpc_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/arpc_engine.sv
// Scan engine: walks the entry RAM once per lookup, insert, refresh or sweep, keeps valid bits and tick count.
module arpc_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  arpc_pkg::in_t                  cmd_i,
  input  logic [arpc_pkg::AGE_W-1:0]     age_limit_i,
  input  logic                           out_free_i,
  output arpc_pkg::eng_stat_t            stat_o,
  output arpc_pkg::out_t                 res_o
);

  arpc_pkg::state_e                   state_q, state_d;
  arpc_pkg::in_t                      cmd_q, cmd_d;
  logic [arpc_pkg::ENTRIES-1:0]       valid_q, valid_d;
  logic [arpc_pkg::TICK_W-1:0]        now_q, now_d;
  logic [arpc_pkg::IDX_W-1:0]         idx_q, idx_d;
  logic                               chk_vld_q, chk_vld_d;
  logic [arpc_pkg::IDX_W-1:0]         chk_idx_q, chk_idx_d;
  logic                               hit_q, hit_d;
  logic [arpc_pkg::IDX_W-1:0]         hit_idx_q, hit_idx_d;
  logic                               free_q, free_d;
  logic [arpc_pkg::IDX_W-1:0]         free_idx_q, free_idx_d;
  logic [arpc_pkg::MAC_W-1:0]         mac_q, mac_d;
  logic [arpc_pkg::CNT_W-1:0]         removed_q, removed_d;

  logic                               rd_en;
  arpc_pkg::entry_t                   rd_data;
  logic                               wr_en;
  logic [arpc_pkg::IDX_W-1:0]         wr_addr;
  arpc_pkg::entry_t                   wr_data;
  logic [arpc_pkg::TICK_W-1:0]        age;
  logic                               ent_vld;
  logic                               is_scan_kind;

  arpc_ram #(
    .DEPTH (arpc_pkg::ENTRIES),
    .WIDTH ($bits(arpc_pkg::entry_t))
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign age     = now_q - rd_data.stamp;
  assign ent_vld = valid_q[chk_idx_q];

  always_comb begin
    unique case (cmd_i.kind) inside
      arpc_pkg::KIND_LOOKUP,
      arpc_pkg::KIND_INSERT,
      arpc_pkg::KIND_REFRESH,
      arpc_pkg::KIND_SWEEP:   is_scan_kind = 1'b1;
      default:                is_scan_kind = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    valid_d    = valid_q;
    now_d      = now_q;
    idx_d      = idx_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    mac_d      = mac_q;
    removed_d  = removed_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = hit_idx_q;
    wr_data    = '{ip: cmd_q.ip_addr, mac: cmd_q.mac_addr, stamp: now_q};
    stat_o     = '{idle: 1'b0, done: 1'b0};
    res_o      = '{status: arpc_pkg::STS_OK, found_mac: '0, removed: '0};

    // check stage: data of chk_idx_q is on the RAM output
    if (chk_vld_q) begin
      if (ent_vld && rd_data.ip == cmd_q.ip_addr && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = chk_idx_q;
        mac_d     = rd_data.mac;
      end
      if (!ent_vld && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = chk_idx_q;
      end
      if (cmd_q.kind == arpc_pkg::KIND_SWEEP && ent_vld &&
          age > {{(arpc_pkg::TICK_W-arpc_pkg::AGE_W){1'b0}}, age_limit_i}) begin
        valid_d[chk_idx_q] = 1'b0;
        if (removed_q != arpc_pkg::CNT_MAX) begin
          removed_d = removed_q + 1'b1;
        end
      end
    end

    unique case (state_q)
      arpc_pkg::S_IDLE: begin
        stat_o.idle = 1'b1;
        if (start_i) begin
          cmd_d     = cmd_i;
          idx_d     = '0;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          removed_d = '0;
          state_d   = is_scan_kind ? arpc_pkg::S_SCAN : arpc_pkg::S_FINISH;
        end
      end
      arpc_pkg::S_SCAN: begin
        rd_en     = 1'b1;
        chk_vld_d = 1'b1;
        chk_idx_d = idx_q;
        idx_d     = idx_q + 1'b1;
        if (idx_q == arpc_pkg::IDX_LAST) begin
          state_d = arpc_pkg::S_LAST;
        end
      end
      arpc_pkg::S_LAST: begin
        state_d = arpc_pkg::S_FINISH;
      end
      arpc_pkg::S_FINISH: begin
        if (out_free_i) begin
          stat_o.done = 1'b1;
          state_d     = arpc_pkg::S_IDLE;
          unique case (cmd_q.kind)
            arpc_pkg::KIND_LOOKUP: begin
              if (hit_q) begin
                res_o.found_mac = mac_q;
              end else begin
                res_o.status = arpc_pkg::STS_MISS;
              end
            end
            arpc_pkg::KIND_INSERT: begin
              if (hit_q || free_q) begin
                wr_en            = 1'b1;
                wr_addr          = hit_q ? hit_idx_q : free_idx_q;
                valid_d[wr_addr] = 1'b1;
              end else begin
                res_o.status = arpc_pkg::STS_FULL;
              end
            end
            arpc_pkg::KIND_REFRESH: begin
              if (hit_q) begin
                wr_en       = 1'b1;
                wr_data.mac = mac_q;
              end else begin
                res_o.status = arpc_pkg::STS_MISS;
              end
            end
            arpc_pkg::KIND_TICK: begin
              now_d = now_q + 1'b1;
            end
            arpc_pkg::KIND_SWEEP: begin
              res_o.removed = removed_q;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = arpc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= arpc_pkg::S_IDLE;
      valid_q   <= '0;
      now_q     <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      now_q     <= now_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    chk_idx_q  <= chk_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    mac_q      <= mac_d;
    removed_q  <= removed_d;
  end

endmodule

### rtl/core/arp_cache_with_aging.sv
// ARP cache with aging: top level with handshakes, age limit register and result register.
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_ready_o   | in_data_i   (arpc_pkg::in_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o  (arpc_pkg::out_t)
//  cfg     | input     | cfg_we_i                  | cfg_wdata_i (age limit)
//
// Lookup, insert, refresh and sweep scan the entry RAM one entry a cycle through its
// single read port, then pass through S_LAST to S_FINISH, where the result is registered.
// Tick and unused kinds go from idle straight to S_FINISH, where the result is registered.
// One transaction is in work at a time.
// Reset clears all valid bits and the tick count at once; no clearing pass.
// A full result register holds the engine in its final state until it is taken.
module arp_cache_with_aging (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  arpc_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output arpc_pkg::out_t             out_data_o,
  input  logic                       cfg_we_i,
  input  logic [arpc_pkg::AGE_W-1:0] cfg_wdata_i
);

  logic [arpc_pkg::AGE_W-1:0] age_limit_q;
  logic                       out_valid_q, out_valid_d;
  arpc_pkg::out_t             out_data_q;
  arpc_pkg::eng_stat_t        stat;
  arpc_pkg::out_t             res;
  logic                       start;
  logic                       out_free;

  assign in_ready_o = stat.idle;
  assign start      = in_valid_i && stat.idle;
  assign out_free   = !out_valid_q || out_ready_i;

  arpc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (in_data_i),
    .age_limit_i (age_limit_q),
    .out_free_i  (out_free),
    .stat_o      (stat),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (stat.done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      age_limit_q <= arpc_pkg::AGE_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        age_limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_done_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> (!out_valid_q || out_ready_i))
    else $error("result posted while result register still held");

  a_done_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |=> out_valid_o)
    else $error("finished transaction not presented");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("engine idle right after accepting a transaction");

endmodule

### sim/testbench.sv
// Self-checking testbench for the ARP cache with aging, with a table predictor and result checks.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned POOL      = 24;
  localparam int unsigned PER_PHASE = 130;
  localparam int unsigned PHASES    = 7;

  // Mirrors the cache table and queues the answers it must give.
  class arp_answer_board;
    bit                          valid_q [arpc_pkg::ENTRIES];
    arpc_pkg::entry_t            slot    [arpc_pkg::ENTRIES];
    logic [arpc_pkg::TICK_W-1:0] now_ticks;
    logic [arpc_pkg::AGE_W-1:0]  age_limit;
    arpc_pkg::out_t              answers_due [$];
    int unsigned                 errors, answered, hits, fulls, swept;
    int unsigned                 kind_seen [8];

    function new();
      now_ticks = '0;
      age_limit = arpc_pkg::AGE_RESET;
      errors    = 0;
      answered  = 0;
      hits      = 0;
      fulls     = 0;
      swept     = 0;
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function int find_ip(logic [arpc_pkg::IP_W-1:0] ip);
      for (int i = 0; i < arpc_pkg::ENTRIES; i++)
        if (valid_q[i] && slot[i].ip == ip) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < arpc_pkg::ENTRIES; i++)
        if (!valid_q[i]) return i;
      return -1;
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction

    function void note_request(arpc_pkg::in_t req);
      arpc_pkg::out_t              ans;
      int                          idx;
      logic [arpc_pkg::TICK_W-1:0] age;
      ans = '0;
      kind_seen[req.kind]++;
      case (req.kind)
        arpc_pkg::KIND_LOOKUP: begin
          idx = find_ip(req.ip_addr);
          if (idx >= 0) begin
            ans.found_mac = slot[idx].mac;
            hits++;
          end else ans.status = arpc_pkg::STS_MISS;
        end
        arpc_pkg::KIND_INSERT: begin
          idx = find_ip(req.ip_addr);
          if (idx < 0) idx = find_free();
          if (idx < 0) begin
            ans.status = arpc_pkg::STS_FULL;
            fulls++;
          end else begin
            valid_q[idx]    = 1'b1;
            slot[idx].ip    = req.ip_addr;
            slot[idx].mac   = req.mac_addr;
            slot[idx].stamp = now_ticks;
          end
        end
        arpc_pkg::KIND_REFRESH: begin
          idx = find_ip(req.ip_addr);
          if (idx >= 0) slot[idx].stamp = now_ticks;
          else ans.status = arpc_pkg::STS_MISS;
        end
        arpc_pkg::KIND_TICK: now_ticks = now_ticks + 1'b1;
        arpc_pkg::KIND_SWEEP: begin
          for (int i = 0; i < arpc_pkg::ENTRIES; i++) begin
            age = now_ticks - slot[i].stamp;
            if (valid_q[i] && age > arpc_pkg::TICK_W'(age_limit)) begin
              valid_q[i] = 1'b0;
              swept++;
              if (ans.removed != arpc_pkg::CNT_MAX) ans.removed = ans.removed + 1'b1;
            end
          end
        end
        default: ;
      endcase
      answers_due.push_back(ans);
    endfunction

    function void mismatch(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    endfunction

    function void check_answer(arpc_pkg::out_t got);
      arpc_pkg::out_t want;
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, got);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      answered++;
      if (got.status !== want.status) mismatch("status", want.status, got.status);
      if (got.found_mac !== want.found_mac) mismatch("found_mac", want.found_mac, got.found_mac);
      if (got.removed !== want.removed) mismatch("removed", want.removed, got.removed);
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  arpc_pkg::in_t                 in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  arpc_pkg::out_t                out_data_o;
  logic                          cfg_we_i    = 1'b0;
  logic [arpc_pkg::AGE_W-1:0]    cfg_wdata_i = '0;

  arp_answer_board               sb;
  logic [arpc_pkg::IP_W-1:0]     ip_pool     [POOL];
  logic [arpc_pkg::AGE_W-1:0]    phase_limit [PHASES];
  int unsigned                   burst_left = 4;
  int unsigned                   rx_mode    = 0;
  int unsigned                   rx_left    = 0;

  arp_cache_with_aging uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(4_000_000);
    $display("%0t: timeout", $time);
    $display("** arp_cache_with_aging: FAILED **");
    $finish;
  end

  // result side: check, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i) sb.check_answer(out_data_o);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end else rx_left--;
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic arpc_pkg::in_t make_req(logic [arpc_pkg::KIND_W-1:0] kind,
                                             logic [arpc_pkg::IP_W-1:0] ip,
                                             logic [arpc_pkg::MAC_W-1:0] mac);
    arpc_pkg::in_t req;
    req.kind     = kind;
    req.ip_addr  = ip;
    req.mac_addr = mac;
    return req;
  endfunction

  function automatic arpc_pkg::in_t random_req();
    arpc_pkg::in_t req;
    int unsigned   pick;
    pick         = $urandom_range(0, 99);
    req.ip_addr  = ip_pool[$urandom_range(0, POOL - 1)];
    req.mac_addr = arpc_pkg::MAC_W'({$urandom(), $urandom()});
    if (pick < 25)      req.kind = arpc_pkg::KIND_LOOKUP;
    else if (pick < 50) req.kind = arpc_pkg::KIND_INSERT;
    else if (pick < 62) req.kind = arpc_pkg::KIND_REFRESH;
    else if (pick < 82) req.kind = arpc_pkg::KIND_TICK;
    else if (pick < 92) req.kind = arpc_pkg::KIND_SWEEP;
    else if (pick < 96) req.kind = arpc_pkg::KIND_W'($urandom_range(5, 7));
    else begin
      req.kind    = $urandom_range(0, 1) ? arpc_pkg::KIND_LOOKUP : arpc_pkg::KIND_REFRESH;
      req.ip_addr = $urandom();
    end
    return req;
  endfunction

  task automatic send_req(input arpc_pkg::in_t req);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(req);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat ($urandom_range(1, 25)) @(posedge clk_i);
    end else burst_left--;
  endtask

  task automatic set_age_limit(input logic [arpc_pkg::AGE_W-1:0] lim);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (arpc_pkg::ENTRIES + 4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.age_limit = lim;
  endtask

  initial begin
    sb = new();
    for (int i = 0; i < POOL; i++) ip_pool[i] = $urandom();
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    phase_limit[0] = '1;
    phase_limit[1] = '0;
    phase_limit[2] = arpc_pkg::AGE_W'(3);
    phase_limit[3] = arpc_pkg::AGE_W'(1);
    phase_limit[4] = arpc_pkg::AGE_W'(12);
    phase_limit[5] = arpc_pkg::AGE_W'($urandom_range(2, 40));
    phase_limit[6] = arpc_pkg::AGE_RESET;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extremes, overwrite, refresh, unused kinds
    send_req(make_req(arpc_pkg::KIND_LOOKUP, '0, '0));
    send_req(make_req(arpc_pkg::KIND_REFRESH, '0, '1));
    send_req(make_req(arpc_pkg::KIND_INSERT, '0, '0));
    send_req(make_req(arpc_pkg::KIND_INSERT, '1, '1));
    send_req(make_req(arpc_pkg::KIND_LOOKUP, '0, '1));
    send_req(make_req(arpc_pkg::KIND_LOOKUP, '1, '0));
    send_req(make_req(arpc_pkg::KIND_INSERT, '1, 48'h5555_aaaa_5555));
    send_req(make_req(arpc_pkg::KIND_LOOKUP, '1, '0));
    send_req(make_req(arpc_pkg::KIND_TICK, '1, '1));
    send_req(make_req(arpc_pkg::KIND_REFRESH, '0, '0));
    send_req(make_req(arpc_pkg::KIND_SWEEP, '0, '0));
    send_req(make_req(3'd5, $urandom(), arpc_pkg::MAC_W'({$urandom(), $urandom()})));
    send_req(make_req(3'd6, $urandom(), arpc_pkg::MAC_W'({$urandom(), $urandom()})));
    send_req(make_req(3'd7, '1, '1));
    send_req(make_req(arpc_pkg::KIND_LOOKUP, 32'haaaa_5555, '0));
    // zero age limit: only entries of nonzero age go
    set_age_limit('0);
    send_req(make_req(arpc_pkg::KIND_INSERT, 32'h1, 48'h0000_0000_0001));
    send_req(make_req(arpc_pkg::KIND_SWEEP, '0, '0));
    send_req(make_req(arpc_pkg::KIND_TICK, '0, '0));
    send_req(make_req(arpc_pkg::KIND_SWEEP, '0, '0));
    send_req(make_req(arpc_pkg::KIND_LOOKUP, 32'h1, '0));

    for (int p = 0; p < PHASES; p++) begin
      set_age_limit(phase_limit[p]);
      repeat (PER_PHASE) send_req(random_req());
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (arpc_pkg::ENTRIES + 8) @(posedge clk_i);

    $display("Sent %0d lookups, %0d inserts, %0d refreshes, %0d ticks, %0d sweeps, %0d unused",
             sb.kind_seen[arpc_pkg::KIND_LOOKUP], sb.kind_seen[arpc_pkg::KIND_INSERT],
             sb.kind_seen[arpc_pkg::KIND_REFRESH], sb.kind_seen[arpc_pkg::KIND_TICK],
             sb.kind_seen[arpc_pkg::KIND_SWEEP],
             sb.kind_seen[5] + sb.kind_seen[6] + sb.kind_seen[7]);
    $display("%0d results checked over %0d age limits: %0d hits, %0d full, %0d aged out",
             sb.answered, PHASES + 1, sb.hits, sb.fulls, sb.swept);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** arp_cache_with_aging: PASSED **");
    end else begin
      $display("** arp_cache_with_aging: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/arpc_pkg.sv
rtl/core/arpc_ram.sv
rtl/core/arpc_engine.sv
rtl/core/arp_cache_with_aging.sv
sim/testbench.sv
